@@ hdl/png_scanline_unfilter_macros.svh @@
// assertion macros shared by the checker of the scanline unfilter
`ifndef PNG_SCANLINE_UNFILTER_MACROS_SVH
`define PNG_SCANLINE_UNFILTER_MACROS_SVH

// antecedent holds -> consequent holds in the same cycle
`define PSU_ASSERT_IMP(lbl, clk, rst_n, ant, con, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (con)) else $error(msg);

// antecedent holds -> consequent holds in the next cycle
`define PSU_ASSERT_NXT(lbl, clk, rst_n, ant, con, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (con)) else $error(msg);

`endif

@@ hdl/psu_pkg.sv @@
// shared types and constants of the scanline unfilter
package psu_pkg;

    localparam int MAX_SCANLINE_BYTES = 16384;
    localparam int MAX_PIXEL_BYTES    = 8;

    localparam int COL_W     = $clog2(MAX_SCANLINE_BYTES);
    localparam int CNT_W     = $clog2(MAX_SCANLINE_BYTES + 1);
    localparam int SLOT_W    = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1;
    localparam int PB_W      = 4;
    localparam int SL_W      = 15;
    localparam int CFG_W     = 15;
    localparam int CFG_IDX_W = 1;
    localparam int CMP_W     = (CNT_W > SL_W) ? CNT_W : SL_W;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PIXEL_BYTES    = 1'b0,
        REG_SCANLINE_BYTES = 1'b1
    } t_cfg_reg;

    typedef enum logic [2:0] {
        FLT_NONE  = 3'd0,
        FLT_SUB   = 3'd1,
        FLT_UP    = 3'd2,
        FLT_AVG   = 3'd3,
        FLT_PAETH = 3'd4,
        FLT_BAD   = 3'd5
    } t_filter;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       pass_start;
    } t_in_item;

    typedef struct packed {
        logic [7:0] pixel_byte;
        logic       row_end;
        logic       bad_filter;
    } t_out_item;

    // data byte on its way from the address stage to the reconstruct stage
    typedef struct packed {
        logic [7:0]        data_byte;
        logic [COL_W-1:0]  col;
        logic [SLOT_W-1:0] slot;
        logic              a_ok;
        logic              b_ok;
        logic              last;
        t_filter           filter;
    } t_s1_item;

    typedef struct packed {
        logic advance;
        logic row_clear;
    } t_recon_ctl;

endpackage

@@ hdl/png_scanline_unfilter.sv @@
// top level of the png scanline unfilter (filter types none, sub, up, average, paeth)
//
//   channel  direction  handshake                 payload
//   in       input      i_in_valid / o_in_ready   i_in_item  (data_byte, pass_start)
//   out      output     o_out_valid / i_out_ready o_out_item (pixel_byte, row_end, bad_filter)
//   cfg      input      i_cfg_we                  i_cfg_index, i_cfg_data
//
// one item per cycle sustained while the output is not stalled; a data byte passes the
// reconstruct stage and the output queue on its way out, a filter byte gives no output item
// the row store read splits the path: address at accept, data in the reconstruct stage
// reset is synchronous; the row store itself is never swept, a fill
// count marks which columns of the current pass hold real data
// a stalled output fills a two-entry queue, input stalls only while that queue is full
// and the reconstruct stage holds an item
module png_scanline_unfilter (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [psu_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [psu_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  psu_pkg::t_in_item             i_in_item,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output psu_pkg::t_out_item            o_out_item
);

    // row store read port (address stage)
    logic                      ram_re;
    logic [psu_pkg::COL_W-1:0] ram_raddr;
    logic [7:0]                ram_rdata;

    // row store write port (reconstruct stage writes the rebuilt byte back)
    logic                      ram_we;
    logic [psu_pkg::COL_W-1:0] ram_waddr;
    logic [7:0]                ram_wdata;

    psu_pkg::t_s1_item   s1;
    psu_pkg::t_recon_ctl ctl;
    psu_pkg::t_out_item  recon_item;
    logic                q_full;

    // filter byte decode, column and pixel slot counters, registers
    psu_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .i_q_full    (q_full),
        .o_ram_re    (ram_re),
        .o_ram_raddr (ram_raddr),
        .o_s1        (s1),
        .o_ctl       (ctl)
    );

    // the row above, one byte per column
    psu_ram #(
        .WIDTH (8),
        .DEPTH (psu_pkg::MAX_SCANLINE_BYTES)
    ) u_row_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // neighbor bytes, prediction and the sum modulo 256
    psu_recon u_recon (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s1        (s1),
        .i_ctl       (ctl),
        .i_rdata     (ram_rdata),
        .o_ram_we    (ram_we),
        .o_ram_waddr (ram_waddr),
        .o_ram_wdata (ram_wdata),
        .o_item      (recon_item)
    );

    // output decoupling
    psu_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (ctl.advance),
        .i_item  (recon_item),
        .o_full  (q_full),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_item  (o_out_item)
    );

endmodule

@@ hdl/psu_ram.sv @@
// generic single-port-write, single-port-read ram with registered read data
module psu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ hdl/psu_ctrl.sv @@
// row tracking, configuration registers and the row store read stage
module psu_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [psu_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [psu_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  psu_pkg::t_in_item             i_in_item,
    input  logic                          i_q_full,
    output logic                          o_ram_re,
    output logic [psu_pkg::COL_W-1:0]     o_ram_raddr,
    output psu_pkg::t_s1_item             o_s1,
    output psu_pkg::t_recon_ctl           o_ctl
);

    localparam int NPB = psu_pkg::MAX_PIXEL_BYTES;

    logic [psu_pkg::PB_W-1:0]   r_pixel_bytes, n_pixel_bytes;
    logic [psu_pkg::SL_W-1:0]   r_scanline_bytes, n_scanline_bytes;
    logic                       r_expect, n_expect;
    logic [psu_pkg::COL_W-1:0]  r_col, n_col;
    logic [psu_pkg::CNT_W-1:0]  r_fill, n_fill;
    psu_pkg::t_filter           r_filter, n_filter;
    logic [psu_pkg::SLOT_W-1:0] r_mod [NPB];
    logic [psu_pkg::SLOT_W-1:0] n_mod [NPB];
    logic                       r_s1_valid, n_s1_valid;
    psu_pkg::t_s1_item          r_s1, n_s1;

    logic [psu_pkg::PB_W-1:0]   pb_eff;
    logic [psu_pkg::CMP_W-1:0]  sl_eff;
    logic [psu_pkg::SLOT_W-1:0] pb_idx;
    logic                       accept, is_filter, data_acc, advance, last;

    // effective register values, out-of-range settings clamp
    always_comb begin
        if (r_pixel_bytes == '0) begin
            pb_eff = psu_pkg::PB_W'(1);
        end else if (r_pixel_bytes > psu_pkg::PB_W'(NPB)) begin
            pb_eff = psu_pkg::PB_W'(NPB);
        end else begin
            pb_eff = r_pixel_bytes;
        end
        if (r_scanline_bytes == '0) begin
            sl_eff = psu_pkg::CMP_W'(1);
        end else if (psu_pkg::CMP_W'(r_scanline_bytes) >
                     psu_pkg::CMP_W'(psu_pkg::MAX_SCANLINE_BYTES)) begin
            sl_eff = psu_pkg::CMP_W'(psu_pkg::MAX_SCANLINE_BYTES);
        end else begin
            sl_eff = psu_pkg::CMP_W'(r_scanline_bytes);
        end
    end

    assign advance    = r_s1_valid && !i_q_full;
    assign o_in_ready = !r_s1_valid || !i_q_full;
    assign accept     = i_in_valid && o_in_ready;
    assign is_filter  = i_in_item.pass_start || r_expect;
    assign data_acc   = accept && !is_filter;
    assign pb_idx     = psu_pkg::SLOT_W'(pb_eff - psu_pkg::PB_W'(1));
    assign last       = (psu_pkg::CMP_W'(r_col) + psu_pkg::CMP_W'(1)) >= sl_eff;

    always_comb begin
        n_pixel_bytes    = r_pixel_bytes;
        n_scanline_bytes = r_scanline_bytes;
        if (i_cfg_we) begin
            unique case (psu_pkg::t_cfg_reg'(i_cfg_index))
                psu_pkg::REG_PIXEL_BYTES:    n_pixel_bytes = i_cfg_data[psu_pkg::PB_W-1:0];
                psu_pkg::REG_SCANLINE_BYTES: n_scanline_bytes = i_cfg_data[psu_pkg::SL_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        n_expect   = r_expect;
        n_col      = r_col;
        n_fill     = r_fill;
        n_filter   = r_filter;
        n_mod      = r_mod;
        n_s1_valid = r_s1_valid;
        n_s1       = r_s1;

        if (advance) begin
            n_s1_valid = 1'b0;
        end

        if (accept && is_filter) begin
            // pass start invalidates the row store by emptying the fill count
            if (i_in_item.pass_start) begin
                n_fill = '0;
            end
            n_filter = (i_in_item.data_byte <= 8'(psu_pkg::FLT_PAETH)) ?
                       psu_pkg::t_filter'(i_in_item.data_byte[2:0]) : psu_pkg::FLT_BAD;
            n_expect = 1'b0;
            n_col    = '0;
            for (int k = 0; k < NPB; k++) begin
                n_mod[k] = '0;
            end
        end else if (data_acc) begin
            n_s1_valid     = 1'b1;
            n_s1.data_byte = i_in_item.data_byte;
            n_s1.col       = r_col;
            n_s1.slot      = r_mod[pb_idx];
            n_s1.a_ok      = psu_pkg::CMP_W'(r_col) >= psu_pkg::CMP_W'(pb_eff);
            n_s1.b_ok      = psu_pkg::CNT_W'(r_col) < r_fill;
            n_s1.last      = last;
            n_s1.filter    = r_filter;
            if (psu_pkg::CNT_W'(r_col) == r_fill) begin
                n_fill = r_fill + psu_pkg::CNT_W'(1);
            end
            if (last) begin
                n_expect = 1'b1;
                n_col    = '0;
            end else begin
                n_col = r_col + psu_pkg::COL_W'(1);
            end
            // column modulo every possible pixel size
            for (int k = 0; k < NPB; k++) begin
                n_mod[k] = (r_mod[k] == psu_pkg::SLOT_W'(k)) ? '0 :
                           r_mod[k] + psu_pkg::SLOT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pixel_bytes    <= psu_pkg::PB_W'(1);
            r_scanline_bytes <= psu_pkg::SL_W'(1);
            r_expect         <= 1'b1;
            r_col            <= '0;
            r_fill           <= '0;
            r_filter         <= psu_pkg::FLT_NONE;
            r_s1_valid       <= 1'b0;
            for (int k = 0; k < NPB; k++) begin
                r_mod[k] <= '0;
            end
        end else begin
            r_pixel_bytes    <= n_pixel_bytes;
            r_scanline_bytes <= n_scanline_bytes;
            r_expect         <= n_expect;
            r_col            <= n_col;
            r_fill           <= n_fill;
            r_filter         <= n_filter;
            r_s1_valid       <= n_s1_valid;
            r_mod            <= n_mod;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1 <= n_s1;
    end

    assign o_ram_re      = data_acc;
    assign o_ram_raddr   = r_col;
    assign o_s1          = r_s1;
    assign o_ctl.advance   = advance;
    assign o_ctl.row_clear = accept && is_filter;

endmodule

@@ hdl/psu_recon.sv @@
// neighbor histories, predictor and byte reconstruction
module psu_recon (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  psu_pkg::t_s1_item         i_s1,
    input  psu_pkg::t_recon_ctl       i_ctl,
    input  logic [7:0]                i_rdata,
    output logic                      o_ram_we,
    output logic [psu_pkg::COL_W-1:0] o_ram_waddr,
    output logic [7:0]                o_ram_wdata,
    output psu_pkg::t_out_item        o_item
);

    localparam int NPB = psu_pkg::MAX_PIXEL_BYTES;

    logic [7:0]     r_left  [NPB];
    logic [7:0]     r_upper [NPB];
    logic [NPB-1:0] r_hvalid, n_hvalid;

    logic [7:0] a, b, c, pred, x;
    logic [8:0] avg_sum;

    function automatic logic [7:0] paeth(input logic [7:0] pa, input logic [7:0] pb,
                                         input logic [7:0] pc);
        logic signed [9:0] va, vb, vc, da, db, dc;
        va = $signed({2'b00, pa});
        vb = $signed({2'b00, pb});
        vc = $signed({2'b00, pc});
        da = vb - vc;
        db = va - vc;
        dc = va + vb - vc - vc;
        if (da < 0) da = -da;
        if (db < 0) db = -db;
        if (dc < 0) dc = -dc;
        if (da <= db && da <= dc) return pa;
        if (db <= dc) return pb;
        return pc;
    endfunction

    always_comb begin
        b = i_s1.b_ok ? i_rdata : 8'h00;
        if (i_s1.a_ok && r_hvalid[i_s1.slot]) begin
            a = r_left[i_s1.slot];
            c = r_upper[i_s1.slot];
        end else begin
            a = 8'h00;
            c = 8'h00;
        end
        avg_sum = {1'b0, a} + {1'b0, b};
        unique case (i_s1.filter)
            psu_pkg::FLT_NONE:  pred = 8'h00;
            psu_pkg::FLT_SUB:   pred = a;
            psu_pkg::FLT_UP:    pred = b;
            psu_pkg::FLT_AVG:   pred = avg_sum[8:1];
            psu_pkg::FLT_PAETH: pred = paeth(a, b, c);
            default:            pred = 8'h00;
        endcase
        x = (i_s1.filter == psu_pkg::FLT_BAD) ? 8'h00 : i_s1.data_byte + pred;
    end

    // row start wins over a late write from the row before
    always_comb begin
        n_hvalid = r_hvalid;
        if (i_ctl.row_clear) begin
            n_hvalid = '0;
        end else if (i_ctl.advance) begin
            n_hvalid[i_s1.slot] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hvalid <= '0;
        end else begin
            r_hvalid <= n_hvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.advance) begin
            r_left[i_s1.slot]  <= x;
            r_upper[i_s1.slot] <= b;
        end
    end

    assign o_ram_we          = i_ctl.advance;
    assign o_ram_waddr       = i_s1.col;
    assign o_ram_wdata       = x;
    assign o_item.pixel_byte = x;
    assign o_item.row_end    = i_s1.last;
    assign o_item.bad_filter = (i_s1.filter == psu_pkg::FLT_BAD);

endmodule

@@ hdl/psu_outq.sv @@
// two-entry output queue between reconstruction and the result channel
module psu_outq (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  psu_pkg::t_out_item i_item,
    output logic               o_full,
    output logic               o_valid,
    input  logic               i_ready,
    output psu_pkg::t_out_item o_item
);

    psu_pkg::t_out_item r_slot [2];
    logic               r_wr_ptr, n_wr_ptr;
    logic               r_rd_ptr, n_rd_ptr;
    logic [1:0]         r_count, n_count;
    logic               pop;

    assign o_valid = (r_count != 2'd0);
    assign o_full  = (r_count == 2'd2);
    assign pop     = o_valid && i_ready;
    assign o_item  = r_slot[r_rd_ptr];

    always_comb begin
        n_wr_ptr = i_push ? ~r_wr_ptr : r_wr_ptr;
        n_rd_ptr = pop ? ~r_rd_ptr : r_rd_ptr;
        n_count  = r_count + 2'(i_push) - 2'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_item;
        end
    end

endmodule

@@ hdl/psu_checker.sv @@
// port-level checks of the scanline unfilter and their binding
`include "png_scanline_unfilter_macros.svh"

module psu_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          o_in_ready,
    input psu_pkg::t_in_item             i_in_item,
    input logic                          o_out_valid,
    input logic                          i_out_ready,
    input psu_pkg::t_out_item            o_out_item
);

    // a waiting output item holds until taken
    `PSU_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out_item), "output item changed while stalled")

    // with nothing queued the block must take input
    `PSU_ASSERT_IMP(a_ready_when_empty, i_clk, i_rst_n, !o_out_valid, o_in_ready, "input stalled with empty output")

    // a bad filter row gives zero bytes
    `PSU_ASSERT_IMP(a_bad_zero, i_clk, i_rst_n, o_out_valid && o_out_item.bad_filter, o_out_item.pixel_byte == 8'h00, "bad filter byte not zero")

    // a new output item comes only from an accepted data byte
    `PSU_ASSERT_IMP(a_out_source, i_clk, i_rst_n, $rose(o_out_valid), $past(i_in_valid && o_in_ready && !i_in_item.pass_start, 2), "output item without a data byte")

endmodule

bind png_scanline_unfilter psu_checker u_psu_checker (.*);

@@ test/tb.sv @@
// self-checking testbench of the png scanline unfilter: directed table, then random rows
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DRAIN_PAUSE  = 8;     // cycles after the last pixel before a register write
    localparam int HOLD_CYCLES  = 200;   // long receiver hold-off to back the block up
    localparam int QUIET_LIMIT  = 3000;  // cycles without any accepted item before giving up
    localparam int NUM_PHASES   = 11;
    localparam int RAND_ITEMS   = 129;   // items per random phase
    localparam int NUM_DIRECTED = 34;

    typedef enum logic [1:0] {
        ROW_CFG,    // register write, taken while the block is idle
        ROW_ITEM,   // byte checked against the predictor
        ROW_KNOWN   // byte with the result typed in
    } t_row_kind;

    typedef struct packed {
        t_row_kind          kind;
        psu_pkg::t_cfg_reg  reg_sel;
        logic [14:0]        reg_val;
        psu_pkg::t_in_item  stim;
        psu_pkg::t_out_item want;
    } t_dir_row;

    // directed table: extremes, every filter type, bad codes, pass start mid-row and a
    // scanline length cut below the current column
    localparam t_dir_row DIRECTED [NUM_DIRECTED] = '{
        // reset setting: one byte per pixel, one byte per scanline
        '{ROW_ITEM,  psu_pkg::REG_PIXEL_BYTES,    15'd0, '{8'h00, 1'b1}, '{8'h00, 1'b0, 1'b0}},
        '{ROW_KNOWN, psu_pkg::REG_PIXEL_BYTES,    15'd0, '{8'hFF, 1'b0}, '{8'hFF, 1'b1, 1'b0}},
        '{ROW_ITEM,  psu_pkg::REG_PIXEL_BYTES,    15'd0, '{8'h01, 1'b0}, '{8'h00, 1'b0, 1'b0}},
        '{ROW_KNOWN, psu_pkg::REG_PIXEL_BYTES,    15'd0, '{8'h00, 1'b0}, '{8'h00, 1'b1, 1'b0}},
        '{ROW_ITEM,  psu_pkg::REG_PIXEL_BYTES,    15'd0, '{8'h02, 1'b0}, '{8'h00, 1'b0, 1'b0}},
        '{ROW_ITEM,  psu_pkg::REG_PIXEL_BYTES,    15'd0, '{8'h80, 1'b0}, '{8'h00, 1'b0, 1'b0}},
        // highest and lowest bad filter codes give zero with the error flag
        '{ROW_ITEM,  psu_pkg::REG_PIXEL_BYTES,    15'd0, '{8'hFF, 1'b0}, '{8'h00, 1'b0, 1'b0}},
        '{ROW_KNOWN, psu_pkg::REG_PIXEL_BYTES,    15'd0, '{8'hA5, 1'b0}, '{8'h00, 1'b1, 1'b1}},
        '{ROW_ITEM,  psu_pkg::REG_PIXEL_BYTES,    15'd0, '{8'h05, 1'b0}, '{8'h00, 1'b0, 1'b0}},
        '{ROW_KNOWN, psu_pkg::REG_PIXEL_BYTES,    15'd0, '{8'h33, 1'b0}, '{8'h00, 1'b1, 1'b1}},
        // two bytes per pixel, four bytes per scanline
        '{ROW_CFG,   psu_pkg::REG_PIXEL_BYTES,    15'd2, '{8'h00, 1'b0}, '{8'h00, 1'b0, 1'b0}},
        '{ROW_CFG,   psu_pkg::REG_SCANLINE_BYTES, 15'd4, '{8'h00, 1'b0}, '{8'h00, 1'b0, 1'b0}},
        '{ROW_ITEM,  psu_pkg::REG_PIXEL_BYTES,    15'd0, '{8'h00, 1'b1}, '{8'h00, 1'b0, 1'b0}},
        '{ROW_KNOWN, psu_pkg::REG_PIXEL_BYTES,    15'd0, '{8'h10, 1'b0}, '{8'h10, 1'b0, 1'b0}},
        '{ROW_KNOWN, psu_pkg::REG_PIXEL_BYTES,    15'd0, '{8'hF0, 1'b0}, '{8'hF0, 1'b0, 1'b0}},
        '{ROW_KNOWN, psu_pkg::REG_PIXEL_BYTES,    15'd0, '{8'hFF, 1'b0}, '{8'hFF, 1'b0, 1'b0}},
        '{ROW_KNOWN, psu_pkg::REG_PIXEL_BYTES,    15'd0, '{8'h01, 1'b0}, '{8'h01, 1'b1, 1'b0}},
        // paeth row over the row above
        '{ROW_ITEM,  psu_pkg::REG_PIXEL_BYTES,    15'd0, '{8'h04, 1'b0}, '{8'h00, 1'b0, 1'b0}},
        '{ROW_ITEM,  psu_pkg::REG_PIXEL_BYTES,    15'd0, '{8'hFF, 1'b0}, '{8'h00, 1'b0, 1'b0}},
        '{ROW_ITEM,  psu_pkg::REG_PIXEL_BYTES,    15'd0, '{8'hFF, 1'b0}, '{8'h00, 1'b0, 1'b0}},
        '{ROW_ITEM,  psu_pkg::REG_PIXEL_BYTES,    15'd0, '{8'h80, 1'b0}, '{8'h00, 1'b0, 1'b0}},
        '{ROW_ITEM,  psu_pkg::REG_PIXEL_BYTES,    15'd0, '{8'h7F, 1'b0}, '{8'h00, 1'b0, 1'b0}},
        // average row
        '{ROW_ITEM,  psu_pkg::REG_PIXEL_BYTES,    15'd0, '{8'h03, 1'b0}, '{8'h00, 1'b0, 1'b0}},
        '{ROW_ITEM,  psu_pkg::REG_PIXEL_BYTES,    15'd0, '{8'h00, 1'b0}, '{8'h00, 1'b0, 1'b0}},
        '{ROW_ITEM,  psu_pkg::REG_PIXEL_BYTES,    15'd0, '{8'hFF, 1'b0}, '{8'h00, 1'b0, 1'b0}},
        '{ROW_ITEM,  psu_pkg::REG_PIXEL_BYTES,    15'd0, '{8'h01, 1'b0}, '{8'h00, 1'b0, 1'b0}},
        '{ROW_ITEM,  psu_pkg::REG_PIXEL_BYTES,    15'd0, '{8'hFE, 1'b0}, '{8'h00, 1'b0, 1'b0}},
        // sub row broken off by a pass start, which then acts as a none filter byte
        '{ROW_ITEM,  psu_pkg::REG_PIXEL_BYTES,    15'd0, '{8'h01, 1'b0}, '{8'h00, 1'b0, 1'b0}},
        '{ROW_ITEM,  psu_pkg::REG_PIXEL_BYTES,    15'd0, '{8'h11, 1'b0}, '{8'h00, 1'b0, 1'b0}},
        '{ROW_ITEM,  psu_pkg::REG_PIXEL_BYTES,    15'd0, '{8'h22, 1'b0}, '{8'h00, 1'b0, 1'b0}},
        '{ROW_ITEM,  psu_pkg::REG_PIXEL_BYTES,    15'd0, '{8'h00, 1'b1}, '{8'h00, 1'b0, 1'b0}},
        '{ROW_KNOWN, psu_pkg::REG_PIXEL_BYTES,    15'd0, '{8'h44, 1'b0}, '{8'h44, 1'b0, 1'b0}},
        // scanline shortened mid-row: the next byte ends the row
        '{ROW_CFG,   psu_pkg::REG_SCANLINE_BYTES, 15'd1, '{8'h00, 1'b0}, '{8'h00, 1'b0, 1'b0}},
        '{ROW_KNOWN, psu_pkg::REG_PIXEL_BYTES,    15'd0, '{8'h55, 1'b0}, '{8'h55, 1'b1, 1'b0}}
    };

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          i_cfg_we;
    logic [psu_pkg::CFG_IDX_W-1:0] i_cfg_index;
    logic [psu_pkg::CFG_W-1:0]     i_cfg_data;
    logic                          i_in_valid;
    logic                          o_in_ready;
    psu_pkg::t_in_item             i_in_item;
    logic                          o_out_valid;
    logic                          i_out_ready;
    psu_pkg::t_out_item            o_out_item;

    png_scanline_unfilter dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

    // predictor state: row store, pixel histories, column position and registers
    logic [7:0]  upper_row [psu_pkg::MAX_SCANLINE_BYTES];
    logic [7:0]  left_bytes [psu_pkg::MAX_PIXEL_BYTES];
    logic [7:0]  upleft_bytes [psu_pkg::MAX_PIXEL_BYTES];
    int          column;        // 0: filter byte next, k: data column k-1 next
    psu_pkg::t_filter cur_filter;
    bit          fresh_pass;
    logic [3:0]  cfg_pixel_bytes;
    logic [14:0] cfg_scan_bytes;

    psu_pkg::t_out_item rebuilt_bytes [$];   // reconstructed bytes still to come out

    int send_gap_pct = 0;
    int recv_gap_pct = 0;
    int hold_asks    = 0;
    int hold_done    = 0;
    int errors       = 0;
    int quiet_cycles = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int paeth_pick(input int a, input int b, input int c);
        int p, da, db, dc;
        p  = a + b - c;
        da = (p > a) ? p - a : a - p;
        db = (p > b) ? p - b : b - p;
        dc = (p > c) ? p - c : c - p;
        if (da <= db && da <= dc) return a;
        if (db <= dc) return b;
        return c;
    endfunction

    // one input byte through the filter reconstruction; returns 1 when it makes a pixel
    function automatic bit unfilter_step(input psu_pkg::t_in_item it,
                                         output psu_pkg::t_out_item res);
        int pb, sl, col, slot, a, b, c, x;
        res = '0;
        pb = (cfg_pixel_bytes == 0) ? 1 :
             (cfg_pixel_bytes > psu_pkg::MAX_PIXEL_BYTES) ? psu_pkg::MAX_PIXEL_BYTES :
             int'(cfg_pixel_bytes);
        sl = (cfg_scan_bytes == 0) ? 1 :
             (cfg_scan_bytes > psu_pkg::MAX_SCANLINE_BYTES) ? psu_pkg::MAX_SCANLINE_BYTES :
             int'(cfg_scan_bytes);
        if (it.pass_start) begin
            foreach (upper_row[i]) upper_row[i] = 8'h00;
            fresh_pass = 1'b1;
            column     = 0;
        end
        if (column == 0) begin
            cur_filter = (it.data_byte <= 8'd4) ? psu_pkg::t_filter'(it.data_byte[2:0]) :
                         psu_pkg::FLT_BAD;
            foreach (left_bytes[i]) begin
                left_bytes[i]   = 8'h00;
                upleft_bytes[i] = 8'h00;
            end
            column = 1;
            return 1'b0;
        end
        col = column - 1;
        if (col >= psu_pkg::MAX_SCANLINE_BYTES) col = psu_pkg::MAX_SCANLINE_BYTES - 1;
        slot = col % pb;
        b = fresh_pass ? 0 : int'(upper_row[col]);
        a = (col >= pb) ? int'(left_bytes[slot]) : 0;
        c = (col >= pb) ? int'(upleft_bytes[slot]) : 0;
        case (cur_filter)
            psu_pkg::FLT_NONE:  x = int'(it.data_byte);
            psu_pkg::FLT_SUB:   x = int'(it.data_byte) + a;
            psu_pkg::FLT_UP:    x = int'(it.data_byte) + b;
            psu_pkg::FLT_AVG:   x = int'(it.data_byte) + ((a + b) >> 1);
            psu_pkg::FLT_PAETH: x = int'(it.data_byte) + paeth_pick(a, b, c);
            default:            x = 0;
        endcase
        left_bytes[slot]   = 8'(x);
        upleft_bytes[slot] = 8'(b);
        upper_row[col]     = 8'(x);
        res.pixel_byte = 8'(x);
        res.row_end    = (col + 1 >= sl);
        res.bad_filter = (cur_filter == psu_pkg::FLT_BAD);
        if (res.row_end) begin
            column     = 0;
            fresh_pass = 1'b0;
        end else begin
            column = col + 2;
        end
        return 1'b1;
    endfunction

    // next random byte: mostly well-formed rows, with bad codes and broken rows when noisy
    function automatic psu_pkg::t_in_item pick_stim(input bit noisy);
        psu_pkg::t_in_item it;
        int                r;
        r = $urandom_range(0, 99);
        if (column == 0) begin
            it.data_byte  = (!noisy || r < 88) ? 8'($urandom_range(0, 4))
                                               : 8'($urandom_range(5, 255));
            it.pass_start = noisy && ($urandom_range(0, 99) < 12);
        end else begin
            it.data_byte  = (r < 10) ? 8'h00 : (r < 20) ? 8'hFF : 8'($urandom_range(0, 255));
            it.pass_start = noisy && ($urandom_range(0, 99) < 2);
        end
        return it;
    endfunction

    // offer one byte with random gaps ahead of it, then record what it should produce
    task automatic offer_byte(input psu_pkg::t_in_item it, input bit typed,
                              input psu_pkg::t_out_item typed_res);
        psu_pkg::t_out_item res;
        @(negedge i_clk);
        while ($urandom_range(0, 99) < send_gap_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_in_item  = it;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        if (unfilter_step(it, res)) begin
            rebuilt_bytes.insert(rebuilt_bytes.size(), typed ? typed_res : res);
        end
    endtask

    // register write once the block has drained
    task automatic write_reg(input psu_pkg::t_cfg_reg sel, input logic [14:0] val);
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (rebuilt_bytes.size() != 0) @(negedge i_clk);
        // a trailing filter byte gives no pixel, so give the pipeline time to settle
        repeat (DRAIN_PAUSE) @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_index = sel;
        i_cfg_data  = val;
        if (sel == psu_pkg::REG_PIXEL_BYTES) cfg_pixel_bytes = val[3:0];
        else cfg_scan_bytes = val;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    // receiver: random back-pressure, plus a long hold-off on request
    initial begin
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_done != hold_asks) begin
                hold_done++;
                i_out_ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end else begin
                i_out_ready = ($urandom_range(0, 99) >= recv_gap_pct);
            end
        end
    end

    // compare each pixel leaving the block with the oldest reconstructed byte
    always @(posedge i_clk) begin
        psu_pkg::t_out_item want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (rebuilt_bytes.size() == 0) begin
                $error("pixel item with none pending: pixel_byte %h row_end %b bad_filter %b",
                       o_out_item.pixel_byte, o_out_item.row_end, o_out_item.bad_filter);
                errors++;
            end else begin
                want = rebuilt_bytes.pop_front();
                if (o_out_item.pixel_byte !== want.pixel_byte) begin
                    $error("pixel_byte: expected %h, got %h", want.pixel_byte,
                           o_out_item.pixel_byte);
                    errors++;
                end
                if (o_out_item.row_end !== want.row_end) begin
                    $error("row_end: expected %b, got %b", want.row_end, o_out_item.row_end);
                    errors++;
                end
                if (o_out_item.bad_filter !== want.bad_filter) begin
                    $error("bad_filter: expected %b, got %b", want.bad_filter,
                           o_out_item.bad_filter);
                    errors++;
                end
            end
        end
    end

    // watchdog on cycles with no item moving on either channel
    initial begin
        while (quiet_cycles < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) quiet_cycles = 0;
            else quiet_cycles++;
        end
        $display("Verification failed");
        $finish;
    end

    initial begin
        int                pb_val, sl_val, n_items;
        bit                noisy;
        psu_pkg::t_in_item it;

        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        i_in_valid  = 1'b0;
        i_in_item   = '0;

        foreach (upper_row[i]) upper_row[i] = 8'h00;
        foreach (left_bytes[i]) begin
            left_bytes[i]   = 8'h00;
            upleft_bytes[i] = 8'h00;
        end
        column          = 0;
        cur_filter      = psu_pkg::FLT_NONE;
        fresh_pass      = 1'b1;
        cfg_pixel_bytes = 4'd1;
        cfg_scan_bytes  = 15'd1;

        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed table
        send_gap_pct = 32;
        recv_gap_pct = 55;
        for (int k = 0; k < NUM_DIRECTED; k++) begin
            case (DIRECTED[k].kind)
                ROW_CFG:   write_reg(DIRECTED[k].reg_sel, DIRECTED[k].reg_val);
                ROW_KNOWN: offer_byte(DIRECTED[k].stim, 1'b1, DIRECTED[k].want);
                default:   offer_byte(DIRECTED[k].stim, 1'b0, DIRECTED[k].want);
            endcase
        end

        // random phases; the last two run long clean rows at and above the largest scanline
        for (int p = 0; p < NUM_PHASES; p++) begin
            if (p < 3) begin
                send_gap_pct = 32;
                recv_gap_pct = 55;
            end else if (p < 6) begin
                send_gap_pct = 55;
                recv_gap_pct = 32;
            end else begin
                send_gap_pct = 0;
                recv_gap_pct = 0;
            end
            case (p)
                0:       begin pb_val = 1;  sl_val = 1;     end
                1:       begin pb_val = 0;  sl_val = 0;     end
                2:       begin pb_val = 8;  sl_val = 8;     end
                3:       begin pb_val = 15; sl_val = 23;    end
                4:       begin pb_val = 3;  sl_val = 7;     end
                9:       begin pb_val = 15; sl_val = 32767; end
                10:      begin pb_val = 5;  sl_val = 16384; end
                default: begin
                    pb_val = $urandom_range(0, 15);
                    sl_val = $urandom_range(1, 48);
                end
            endcase
            write_reg(psu_pkg::REG_PIXEL_BYTES, 15'(pb_val));
            write_reg(psu_pkg::REG_SCANLINE_BYTES, 15'(sl_val));
            noisy   = (p < 9);
            n_items = RAND_ITEMS;
            // block fills up and stalls its input while the receiver holds off
            if (p == 1 || p == 7) hold_asks++;
            for (int i = 0; i < n_items; i++) begin
                it = pick_stim(noisy);
                // the first long row starts a fresh pass with a good filter code
                if (p == 9 && i == 0) begin
                    it.data_byte  = 8'($urandom_range(0, 4));
                    it.pass_start = 1'b1;
                end
                offer_byte(it, 1'b0, '0);
            end
        end

        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (rebuilt_bytes.size() != 0) @(negedge i_clk);
        repeat (DRAIN_PAUSE) @(negedge i_clk);
        if (errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

@@ png_scanline_unfilter.f @@
+incdir+hdl
hdl/psu_pkg.sv
hdl/psu_ram.sv
hdl/psu_ctrl.sv
hdl/psu_recon.sv
hdl/psu_outq.sv
hdl/png_scanline_unfilter.sv
hdl/psu_checker.sv
test/tb.sv
